>>> sv/dsn_pkg.sv
// Shared types and constants of the decimal to scientific normalizer.
// Holds the command item passed from the front parser to the back sequencer.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package dsn_pkg;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_POINT = 8'h2E;

	localparam int DIGIT_W = 4;
	localparam int COUNT_W = 6;
	localparam int EXP_W   = 11;

	localparam logic signed [EXP_W-1:0] EXP_MAX = 11'sd1023;
	localparam logic signed [EXP_W-1:0] EXP_MIN = -11'sd1023;

	localparam logic [COUNT_W-1:0] SIG_DIGITS_RESET = 6'd4;

	typedef struct packed {
		logic                      emit;
		logic [DIGIT_W-1:0]        digit;
		logic [COUNT_W-1:0]        pad;
		logic                      last;
		logic signed [EXP_W-1:0]   expo;
	} cmd_t;

endpackage

`default_nettype wire

>>> sv/dsn_front.sv
// Front parser: accepts characters, tracks leading zeros, the point and the exponent.
// Pushes one command item per character into the queue; holds the sig_digits register.
// Depends on dsn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dsn_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [7:0]                  char_code,
	input  wire logic                        last_char,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [dsn_pkg::COUNT_W-1:0] cfg_sig_digits,
	input  wire logic                        full,
	output logic                             push,
	output dsn_pkg::cmd_t                    cmd
);

	logic [dsn_pkg::COUNT_W-1:0]       sig_digits_q;
	logic                              signif_q;
	logic                              point_q;
	logic signed [dsn_pkg::EXP_W-1:0]  exp_q;
	logic [dsn_pkg::COUNT_W-1:0]       emitted_q;

	logic                              signif_n;
	logic                              point_n;
	logic signed [dsn_pkg::EXP_W-1:0]  exp_n;
	logic [dsn_pkg::COUNT_W-1:0]       emitted_n;
	logic                              is_digit;
	logic                              is_point;
	logic [7:0]                        diff;
	logic [dsn_pkg::DIGIT_W-1:0]       digit;
	logic                              emit;

	assign in_stall  = full;
	assign push      = in_valid && !full;
	assign cfg_ready = 1'b1;

	assign is_point = (char_code == dsn_pkg::CH_POINT);
	assign is_digit = (char_code >= dsn_pkg::CH_ZERO) && (char_code <= dsn_pkg::CH_NINE);
	assign diff     = char_code - dsn_pkg::CH_ZERO;
	assign digit    = diff[dsn_pkg::DIGIT_W-1:0];

	always_comb begin
		signif_n  = signif_q;
		point_n   = point_q | is_point;
		exp_n     = exp_q;
		emitted_n = emitted_q;
		emit      = 1'b0;
		if (is_digit) begin
			if (!signif_q && digit == '0) begin
				if (point_q && exp_q > dsn_pkg::EXP_MIN) begin
					exp_n = exp_q - 11'sd1;
				end
			end else begin
				if (!signif_q) begin
					signif_n = 1'b1;
					if (!point_q) begin
						exp_n = 11'sd1;
					end
				end else if (!point_q && exp_q < dsn_pkg::EXP_MAX) begin
					exp_n = exp_q + 11'sd1;
				end
				if (emitted_q < sig_digits_q) begin
					emit      = 1'b1;
					emitted_n = emitted_q + 6'd1;
				end
			end
		end
	end

	always_comb begin
		cmd.emit  = emit;
		cmd.digit = digit;
		cmd.last  = last_char;
		cmd.pad   = '0;
		cmd.expo  = signif_n ? exp_n : '0;
		if (last_char && emitted_n < sig_digits_q) begin
			cmd.pad = sig_digits_q - emitted_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sig_digits_q <= dsn_pkg::SIG_DIGITS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			sig_digits_q <= cfg_sig_digits;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			signif_q  <= 1'b0;
			point_q   <= 1'b0;
			exp_q     <= '0;
			emitted_q <= '0;
		end else if (push) begin
			if (last_char) begin
				signif_q  <= 1'b0;
				point_q   <= 1'b0;
				exp_q     <= '0;
				emitted_q <= '0;
			end else begin
				signif_q  <= signif_n;
				point_q   <= point_n;
				exp_q     <= exp_n;
				emitted_q <= emitted_n;
			end
		end
	end

endmodule

`default_nettype wire

>>> sv/dsn_queue.sv
// Short command queue between the front parser and the back sequencer.
// A small register file with wrap-around pointers and an occupancy count.
// Depends on dsn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dsn_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire dsn_pkg::cmd_t wdata,
	input  wire logic          pop,
	output dsn_pkg::cmd_t      head,
	output logic               full,
	output logic               empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	dsn_pkg::cmd_t   mem [DEPTH];
	logic [PW-1:0]   wr_q;
	logic [PW-1:0]   rd_q;
	logic [CW-1:0]   count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

>>> sv/dsn_back.sv
// Back sequencer: turns each command item into digit, pad and exponent records.
// Emits at most one record per cycle, none while out_stall holds it, into a registered output stage.
// Depends on dsn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dsn_back (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire dsn_pkg::cmd_t                     head,
	input  wire logic                              empty,
	output logic                                   pop,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic                                   is_exponent,
	output logic [dsn_pkg::DIGIT_W-1:0]            digit_value,
	output logic signed [dsn_pkg::EXP_W-1:0]       exponent_value,
	output logic                                   last_result
);

	logic                                busy_q;
	dsn_pkg::cmd_t                       cmd_q;
	logic                                valid_q;
	logic                                is_exp_q;
	logic [dsn_pkg::DIGIT_W-1:0]         digit_q;
	logic signed [dsn_pkg::EXP_W-1:0]    expo_q;

	dsn_pkg::cmd_t                       cur;
	dsn_pkg::cmd_t                       nxt;
	logic                                cur_ok;
	logic                                load;
	logic                                step;
	logic                                more;
	logic                                rec_v;
	logic                                rec_exp;
	logic [dsn_pkg::DIGIT_W-1:0]         rec_dig;
	logic signed [dsn_pkg::EXP_W-1:0]    rec_e;

	assign cur    = busy_q ? cmd_q : head;
	assign cur_ok = busy_q || !empty;
	assign load   = !valid_q || !out_stall;
	assign step   = load && cur_ok;
	assign pop    = step && !busy_q;

	always_comb begin
		nxt     = cur;
		rec_v   = 1'b0;
		rec_exp = 1'b0;
		rec_dig = '0;
		rec_e   = '0;
		if (cur.emit) begin
			rec_v    = 1'b1;
			rec_dig  = cur.digit;
			nxt.emit = 1'b0;
		end else if (cur.pad != '0) begin
			rec_v   = 1'b1;
			nxt.pad = cur.pad - 6'd1;
		end else if (cur.last) begin
			rec_v    = 1'b1;
			rec_exp  = 1'b1;
			rec_e    = cur.expo;
			nxt.last = 1'b0;
		end
	end

	assign more = nxt.emit || (nxt.pad != '0) || nxt.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			valid_q <= 1'b0;
		end else if (step) begin
			busy_q  <= more;
			valid_q <= rec_v;
		end else if (load) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			cmd_q    <= nxt;
			is_exp_q <= rec_exp;
			digit_q  <= rec_dig;
			expo_q   <= rec_e;
		end
	end

	assign out_valid      = valid_q;
	assign is_exponent    = is_exp_q;
	assign digit_value    = digit_q;
	assign exponent_value = expo_q;
	assign last_result    = is_exp_q;

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (cmd_q.emit || cmd_q.pad != '0 || cmd_q.last))
		else $error("Held command has no record left.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !is_exp_q) |-> (digit_q <= 4'd9))
		else $error("Digit record out of range.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && is_exp_q) |-> (expo_q >= dsn_pkg::EXP_MIN && expo_q <= dsn_pkg::EXP_MAX))
		else $error("Exponent record out of range.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !is_exp_q) |-> (expo_q == '0))
		else $error("Digit record carries an exponent.");
`endif

endmodule

`default_nettype wire

>>> sv/decimal_to_scientific_normalizer.sv
// Top level of the decimal to scientific normalizer: front parser, command queue,
// back record sequencer. Depends on dsn_pkg, dsn_front, dsn_queue and dsn_back.
//
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_stall    char_code, last_char
// out       output     out_valid / out_stall  is_exponent, digit_value, exponent_value,
//                                             last_result
// cfg       input      cfg_valid / cfg_ready  cfg_sig_digits
//
// The front takes one character per cycle while the queue has room.
// The back sequencer emits at most one record per cycle while out_stall is low; an
// item held for several records (its digit, each pad digit and the exponent record)
// backs up into the queue of QUEUE_DEPTH items, which absorbs it before in_stall rises.
// Reset clears all parse state and sets sig_digits to 4; output stalls back up
// through the queue to the input.
`timescale 1ns / 1ps
`default_nettype none

module decimal_to_scientific_normalizer #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [7:0]                  char_code,
	input  wire logic                        last_char,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [dsn_pkg::COUNT_W-1:0] cfg_sig_digits,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic                             is_exponent,
	output logic [dsn_pkg::DIGIT_W-1:0]      digit_value,
	output logic signed [dsn_pkg::EXP_W-1:0] exponent_value,
	output logic                             last_result
);

	dsn_pkg::cmd_t push_cmd;
	dsn_pkg::cmd_t head_cmd;
	logic          push;
	logic          pop;
	logic          full;
	logic          empty;

	dsn_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.char_code      (char_code),
		.last_char      (last_char),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_sig_digits (cfg_sig_digits),
		.full           (full),
		.push           (push),
		.cmd            (push_cmd)
	);

	dsn_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_cmd),
		.pop    (pop),
		.head   (head_cmd),
		.full   (full),
		.empty  (empty)
	);

	dsn_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head_cmd),
		.empty          (empty),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.is_exponent    (is_exponent),
		.digit_value    (digit_value),
		.exponent_value (exponent_value),
		.last_result    (last_result)
	);

endmodule

`default_nettype wire

>>> dv/dsn_record_checker.sv
// Checker for the decimal to scientific normalizer: watches the character, record and
// budget channels, predicts the records of every accepted character and compares them.
// Depends on dsn_pkg.
`timescale 1ns / 1ps

module dsn_record_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_stall,
	input wire logic [7:0]                  char_code,
	input wire logic                        last_char,
	input wire logic                        cfg_valid,
	input wire logic                        cfg_ready,
	input wire logic [dsn_pkg::COUNT_W-1:0] cfg_sig_digits,
	input wire logic                        out_valid,
	input wire logic                        out_stall,
	input wire logic                        is_exponent,
	input wire logic [dsn_pkg::DIGIT_W-1:0] digit_value,
	input wire logic signed [dsn_pkg::EXP_W-1:0] exponent_value,
	input wire logic                        last_result,
	output int                              mismatch_count,
	output int                              records_due
);

	typedef struct packed {
		logic                             is_exp;
		logic [dsn_pkg::DIGIT_W-1:0]      digit;
		logic signed [dsn_pkg::EXP_W-1:0] expo;
		logic                             last;
	} record_t;

	record_t                          expected_records[$];
	record_t                          want;
	logic [dsn_pkg::COUNT_W-1:0]      budget;
	logic [dsn_pkg::COUNT_W-1:0]      emitted;
	logic                             significant;
	logic                             point_seen;
	logic signed [dsn_pkg::EXP_W-1:0] power;

	task automatic clear_number();
		significant = 1'b0;
		point_seen = 1'b0;
		power = '0;
		emitted = '0;
	endtask

	task automatic predict_records(input logic [7:0] ch, input logic close);
		logic [7:0]                  offset;
		logic [dsn_pkg::DIGIT_W-1:0] d;
		offset = ch - dsn_pkg::CH_ZERO;
		d = offset[dsn_pkg::DIGIT_W-1:0];
		if (ch == dsn_pkg::CH_POINT) begin
			point_seen = 1'b1;
		end else if (ch >= dsn_pkg::CH_ZERO && ch <= dsn_pkg::CH_NINE) begin
			if (!significant && d == 0) begin
				if (point_seen && power != dsn_pkg::EXP_MIN)
					power = power - 11'sd1;
			end else begin
				if (!significant) begin
					significant = 1'b1;
					if (!point_seen)
						power = 11'sd1;
				end else if (!point_seen && power != dsn_pkg::EXP_MAX) begin
					power = power + 11'sd1;
				end
				if (emitted < budget) begin
					expected_records.push_back('{is_exp: 1'b0, digit: d, expo: '0,
						last: 1'b0});
					emitted = emitted + 1'b1;
				end
			end
		end
		if (close) begin
			while (emitted < budget) begin
				expected_records.push_back('{is_exp: 1'b0, digit: '0, expo: '0,
					last: 1'b0});
				emitted = emitted + 1'b1;
			end
			expected_records.push_back('{is_exp: 1'b1, digit: '0,
				expo: significant ? power : '0, last: 1'b1});
			clear_number();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget = dsn_pkg::SIG_DIGITS_RESET;
			clear_number();
			expected_records.delete();
			mismatch_count = 0;
			records_due = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				budget = cfg_sig_digits;
			if (in_valid && !in_stall)
				predict_records(char_code, last_char);
			if (out_valid && !out_stall) begin
				if (expected_records.size() == 0) begin
					$display("%0t: record expected none, actual exp=%0b digit=%0d expo=%0d last=%0b",
						$time, is_exponent, digit_value, exponent_value, last_result);
					mismatch_count++;
				end else begin
					want = expected_records.pop_front();
					if (is_exponent !== want.is_exp) begin
						$display("%0t: is_exponent expected %0b, actual %0b",
							$time, want.is_exp, is_exponent);
						mismatch_count++;
					end
					if (digit_value !== want.digit) begin
						$display("%0t: digit_value expected %0d, actual %0d",
							$time, want.digit, digit_value);
						mismatch_count++;
					end
					if (exponent_value !== want.expo) begin
						$display("%0t: exponent_value expected %0d, actual %0d",
							$time, want.expo, exponent_value);
						mismatch_count++;
					end
					if (last_result !== want.last) begin
						$display("%0t: last_result expected %0b, actual %0b",
							$time, want.last, last_result);
						mismatch_count++;
					end
				end
			end
			records_due = expected_records.size();
		end
	end

endmodule

>>> dv/decimal_to_scientific_normalizer_tb.sv
// Testbench top of the decimal to scientific normalizer: drives characters and budget
// writes with random gaps and output stalls, and gives the verdict.
// Depends on dsn_pkg, decimal_to_scientific_normalizer and dsn_record_checker.
`timescale 1ns / 1ps

module decimal_to_scientific_normalizer_tb;

	localparam int SETTLE_CYCLES = 12;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             in_valid = 1'b0;
	logic [7:0]                       char_code = '0;
	logic                             last_char = 1'b0;
	logic                             cfg_valid = 1'b0;
	logic [dsn_pkg::COUNT_W-1:0]      cfg_sig_digits = '0;
	logic                             out_stall = 1'b0;
	logic                             in_stall;
	logic                             cfg_ready;
	logic                             out_valid;
	logic                             is_exponent;
	logic [dsn_pkg::DIGIT_W-1:0]      digit_value;
	logic signed [dsn_pkg::EXP_W-1:0] exponent_value;
	logic                             last_result;
	int                               mismatch_count;
	int                               records_due;
	bit                               in_quiet = 1'b0;
	bit                               out_quiet = 1'b0;
	int                               chars_sent = 0;
	logic [7:0]                       text[$];

	decimal_to_scientific_normalizer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.char_code(char_code),
		.last_char(last_char),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_sig_digits(cfg_sig_digits),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.is_exponent(is_exponent),
		.digit_value(digit_value),
		.exponent_value(exponent_value),
		.last_result(last_result)
	);

	dsn_record_checker record_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.char_code(char_code),
		.last_char(last_char),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_sig_digits(cfg_sig_digits),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.is_exponent(is_exponent),
		.digit_value(digit_value),
		.exponent_value(exponent_value),
		.last_result(last_result),
		.mismatch_count(mismatch_count),
		.records_due(records_due)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		out_stall <= !out_quiet && ($urandom_range(0, 99) < 36);
	end

	initial begin
		#8_000_000;
		$display("TB_ERROR");
		$finish;
	end

	task automatic send_char(input logic [7:0] ch, input logic close);
		while (!in_quiet && $urandom_range(0, 99) < 36) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		char_code <= ch;
		last_char <= close;
		do @(posedge clk); while (in_stall);
		chars_sent++;
	endtask

	task automatic send_text(input logic close);
		foreach (text[i])
			send_char(text[i], close && i == text.size() - 1);
	endtask

	function automatic void load_text(input string s);
		text.delete();
		for (int i = 0; i < s.len(); i++)
			text.push_back(s[i]);
	endfunction

	task automatic settle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (records_due != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_budget(input logic [dsn_pkg::COUNT_W-1:0] value);
		settle();
		cfg_valid <= 1'b1;
		cfg_sig_digits <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic build_number();
		text.delete();
		repeat ($urandom_range(0, 3)) text.push_back(dsn_pkg::CH_ZERO);
		repeat ($urandom_range(0, 5))
			text.push_back(dsn_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
		if ($urandom_range(0, 2) != 0) begin
			text.push_back(dsn_pkg::CH_POINT);
			repeat ($urandom_range(0, 4)) text.push_back(dsn_pkg::CH_ZERO);
			repeat ($urandom_range(0, 6))
				text.push_back(dsn_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
		end
		if ($urandom_range(0, 9) == 0)
			text.insert($urandom_range(0, text.size()), 8'($urandom_range(0, 255)));
		if (text.size() == 0)
			text.push_back(dsn_pkg::CH_ZERO);
	endtask

	task automatic build_noise();
		text.delete();
		repeat ($urandom_range(1, 8)) begin
			if ($urandom_range(0, 1) == 0)
				text.push_back(dsn_pkg::CH_ZERO + 8'($urandom_range(0, 10)) - 8'd2);
			else
				text.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		int number;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		load_text("0");
		send_text(1'b1);
		load_text("0.0");
		send_text(1'b1);
		load_text("1.2.3");
		send_text(1'b1);
		load_text("0.007");
		send_text(1'b1);
		load_text("98765");
		send_text(1'b1);
		text.delete();
		text.push_back(dsn_pkg::CH_ZERO + 8'd7);
		text.push_back(8'hFF);
		send_text(1'b1);

		write_budget(6'd0);
		load_text("5");
		send_text(1'b1);
		write_budget(6'd63);
		load_text("3.14");
		send_text(1'b1);
		write_budget(6'd6);
		load_text("123");
		send_text(1'b0);
		write_budget(6'd2);
		load_text("4");
		send_text(1'b1);

		number = 0;
		while (chars_sent < 370) begin
			if (number % 8 == 0) begin
				case ($urandom_range(0, 9))
					0: write_budget(6'd63);
					1: write_budget(6'd1);
					default: write_budget(6'($urandom_range(1, 8)));
				endcase
			end
			in_quiet = number >= 12 && number < 20;
			out_quiet = in_quiet;
			if ($urandom_range(0, 99) < 80)
				build_number();
			else
				build_noise();
			send_text(1'b1);
			number++;
		end
		in_quiet = 1'b0;
		out_quiet = 1'b0;

		settle();
		if (mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

>>> filelist.f
sv/dsn_pkg.sv
sv/dsn_front.sv
sv/dsn_queue.sv
sv/dsn_back.sv
sv/decimal_to_scientific_normalizer.sv
dv/dsn_record_checker.sv
dv/decimal_to_scientific_normalizer_tb.sv
